// File: hw/rtl/hrld_pkg.sv
package hrld_pkg;

    // input kinds carried on tuser
    localparam logic OP_TABLE = 1'b0;
    localparam logic OP_BYTE  = 1'b1;

    // register indexes
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam int CFG_W   = 11;
    localparam int IN_W    = 24;
    localparam int GROUP_W = 64;
    localparam int COUNT_W = 5;
    localparam int OUT_W   = 72;

    localparam logic [7:0] LEAF_RUN_BASE = 8'h90;
    localparam logic [4:0] GROUP_PIXELS  = 5'h10;
    localparam logic [10:0] WIDTH_RESET  = 11'd320;
    localparam logic [10:0] HEIGHT_RESET = 11'd200;

    typedef logic [GROUP_W-1:0] group_t;

endpackage

// File: hw/rtl/huffman_rle_delta_image_decoder_top.sv
// decoding: each code bit is a table read, then decode, and each pixel a row read,
// then place; a full or final group is presented the cycle after its last pixel is placed
// flow: one input beat at a time; a code byte holds the input until its pixels are placed,
// including any output stall, and an overrun byte until its error beat is issued
// reset: rst_n asynchronous, active low; clears frame state and sets 320x200;
// the table and row memories are not cleared
module huffman_rle_delta_image_decoder_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // table_addr[7:0], table_data[15:8], code_byte[23:16]
    input  logic [hrld_pkg::IN_W-1:0]  s_tdata,
    // op
    input  logic                       s_tuser,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // pixel_group[63:0], pixel_count[68:64], zero[71:69]
    output logic [hrld_pkg::OUT_W-1:0] m_tdata,
    // frame_end
    output logic                       m_tlast,
    // overrun_error
    output logic                       m_tuser,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [hrld_pkg::CFG_W-1:0] cfg_data
);
    import hrld_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WB = $clog2(MAX_WIDTH + 1);
    localparam int HB = $clog2(MAX_HEIGHT + 1);
    localparam int EW = (WB > CFG_W) ? WB : CFG_W;
    localparam int EH = (HB > CFG_W) ? HB : CFG_W;
    localparam int PW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int BW = PW + 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_TRD  = 3'd1;
    localparam logic [2:0] S_LEAF = 3'd2;
    localparam logic [2:0] S_PRD  = 3'd3;
    localparam logic [2:0] S_PIX  = 3'd4;
    localparam logic [2:0] S_ERR  = 3'd5;

    logic [7:0]  table_mem [256];
    logic [3:0]  row_mem [MAX_WIDTH];

    logic [2:0]        state_reg, state_next;
    logic [CFG_W-1:0]  width_reg, height_reg;
    logic [6:0]        node_reg, node_next;
    logic [3:0]        colour_reg, colour_next;
    logic [PW-1:0]     pos_reg, pos_next;
    logic [CW-1:0]     col_reg, col_next;
    logic [BW-1:0]     bytes_reg, bytes_next;
    group_t            group_reg, group_next;
    logic [3:0]        fill_reg, fill_next;
    logic [7:0]        byte_reg, byte_next;
    logic [2:0]        bit_reg, bit_next;
    logic [6:0]        run_reg, run_next;
    logic [7:0]        tbl_q;
    logic [3:0]        row_q;
    logic              out_valid_reg, out_valid_next;
    group_t            out_group_reg, out_group_next;
    logic [COUNT_W-1:0] out_count_reg, out_count_next;
    logic              out_end_reg, out_end_next;
    logic              out_err_reg, out_err_next;

    logic [EW-1:0] w_ext;
    logic [EH-1:0] h_ext;
    logic [WB-1:0] w_eff;
    logic [HB-1:0] h_eff;
    logic [PW-1:0] total;
    logic          out_free;
    logic          row_we;
    logic [3:0]    pix;
    logic          frame_done;
    group_t        group_pix;
    logic [7:0]    run_sub;

    // effective frame size
    always_comb
    begin
        w_ext = EW'(width_reg);
        h_ext = EH'(height_reg);
        if (w_ext == '0)
            w_ext = EW'(1);
        if (w_ext > EW'(MAX_WIDTH))
            w_ext = EW'(MAX_WIDTH);
        if (h_ext == '0)
            h_ext = EH'(1);
        if (h_ext > EH'(MAX_HEIGHT))
            h_ext = EH'(MAX_HEIGHT);
        w_eff = WB'(w_ext);
        h_eff = HB'(h_ext);
        total = PW'(w_eff) * PW'(h_eff);
    end

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_count_reg, out_group_reg};
    assign m_tlast  = out_end_reg;
    assign m_tuser  = out_err_reg;

    // pixel after the vertical xor
    assign pix = colour_reg ^ ((pos_reg >= PW'(w_eff)) ? row_q : 4'h0);
    assign frame_done = (pos_reg + PW'(1)) >= total;
    assign run_sub = tbl_q - LEAF_RUN_BASE;

    always_comb
    begin
        group_pix = group_reg;
        group_pix[{fill_reg, 2'b00} +: 4] = pix;
    end

    // decoder sequencer
    always_comb
    begin
        state_next     = state_reg;
        node_next      = node_reg;
        colour_next    = colour_reg;
        pos_next       = pos_reg;
        col_next       = col_reg;
        bytes_next     = bytes_reg;
        group_next     = group_reg;
        fill_next      = fill_reg;
        byte_next      = byte_reg;
        bit_next       = bit_reg;
        run_next       = run_reg;
        row_we         = 1'b0;
        out_valid_next = out_valid_reg && !m_tready;
        out_group_next = out_group_reg;
        out_count_next = out_count_reg;
        out_end_next   = out_end_reg;
        out_err_next   = out_err_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid && s_tuser == OP_BYTE)
                begin
                    bytes_next = bytes_reg + BW'(1);
                    byte_next  = s_tdata[23:16];
                    bit_next   = 3'd7;
                    state_next = ((bytes_reg + BW'(1)) > BW'(total)) ? S_ERR : S_TRD;
                end
            end
            S_TRD:
                state_next = S_LEAF;
            S_LEAF:
            begin
                byte_next = {byte_reg[6:0], 1'b0};
                if (!tbl_q[7])
                begin
                    node_next = tbl_q[6:0];
                    bit_next  = bit_reg - 3'd1;
                    state_next = (bit_reg == 3'd0) ? S_IDLE : S_TRD;
                end
                else
                begin
                    node_next  = 7'd0;
                    state_next = S_PRD;
                    if (tbl_q < LEAF_RUN_BASE)
                    begin
                        colour_next = tbl_q[3:0];
                        run_next    = 7'd1;
                    end
                    else
                        run_next = run_sub[6:0] + 7'd1;
                end
            end
            S_PRD:
                state_next = S_PIX;
            S_PIX:
            begin
                if (out_free || !(fill_reg == 4'hf || frame_done))
                begin
                    row_we   = 1'b1;
                    pos_next = pos_reg + PW'(1);
                    col_next = ((WB'(col_reg) + WB'(1)) >= w_eff) ? '0 : col_reg + CW'(1);
                    run_next = run_reg - 7'd1;
                    if (fill_reg == 4'hf || frame_done)
                    begin
                        out_valid_next = 1'b1;
                        out_group_next = group_pix;
                        out_count_next = COUNT_W'(fill_reg) + COUNT_W'(1);
                        out_end_next   = frame_done;
                        out_err_next   = 1'b0;
                        group_next     = '0;
                        fill_next      = 4'h0;
                    end
                    else
                    begin
                        group_next = group_pix;
                        fill_next  = fill_reg + 4'h1;
                    end
                    if (frame_done)
                    begin
                        node_next   = 7'd0;
                        colour_next = 4'h0;
                        pos_next    = '0;
                        col_next    = '0;
                        bytes_next  = '0;
                        state_next  = S_IDLE;
                    end
                    else if (run_reg > 7'd1)
                        state_next = S_PRD;
                    else
                    begin
                        bit_next   = bit_reg - 3'd1;
                        state_next = (bit_reg == 3'd0) ? S_IDLE : S_TRD;
                    end
                end
            end
            S_ERR:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_group_next = '0;
                    out_count_next = '0;
                    out_end_next   = 1'b1;
                    out_err_next   = 1'b1;
                    node_next      = 7'd0;
                    colour_next    = 4'h0;
                    pos_next       = '0;
                    col_next       = '0;
                    bytes_next     = '0;
                    group_next     = '0;
                    fill_next      = 4'h0;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
        // a register write aborts the frame
        if (cfg_we)
        begin
            node_next   = 7'd0;
            colour_next = 4'h0;
            pos_next    = '0;
            col_next    = '0;
            bytes_next  = '0;
            group_next  = '0;
            fill_next   = 4'h0;
        end
    end

    // control and frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            width_reg     <= WIDTH_RESET;
            height_reg    <= HEIGHT_RESET;
            node_reg      <= '0;
            colour_reg    <= '0;
            pos_reg       <= '0;
            col_reg       <= '0;
            bytes_reg     <= '0;
            group_reg     <= '0;
            fill_reg      <= '0;
            bit_reg       <= '0;
            run_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            node_reg      <= node_next;
            colour_reg    <= colour_next;
            pos_reg       <= pos_next;
            col_reg       <= col_next;
            bytes_reg     <= bytes_next;
            group_reg     <= group_next;
            fill_reg      <= fill_next;
            bit_reg       <= bit_next;
            run_reg       <= run_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we && cfg_index == REG_WIDTH)
                width_reg <= cfg_data;
            if (cfg_we && cfg_index == REG_HEIGHT)
                height_reg <= cfg_data;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        byte_reg      <= byte_next;
        out_group_reg <= out_group_next;
        out_count_reg <= out_count_next;
        out_end_reg   <= out_end_next;
        out_err_reg   <= out_err_next;
    end

    // decode table memory
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && s_tvalid && s_tuser == OP_TABLE)
            table_mem[s_tdata[7:0]] <= s_tdata[15:8];
        tbl_q <= table_mem[{node_reg, byte_reg[7]}];
    end

    // row above memory
    always_ff @(posedge clk)
    begin
        if (row_we)
            row_mem[col_reg] <= pix;
        row_q <= row_mem[col_reg];
    end

endmodule

// File: hw/rtl/hrld_checker.sv
module hrld_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [hrld_pkg::OUT_W-1:0] m_tdata,
    input logic                       m_tlast,
    input logic                       m_tuser
);
    import hrld_pkg::*;

    // a waiting beat is held
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output beat dropped while stalled");

    // an overrun beat ends the frame and carries no pixels
    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast && m_tdata[GROUP_W +: COUNT_W] == '0
            && m_tdata[GROUP_W-1:0] == '0)
        else $error("bad overrun beat");

    // a normal beat holds one to sixteen pixels
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[GROUP_W +: COUNT_W] != '0
            && m_tdata[GROUP_W +: COUNT_W] <= GROUP_PIXELS)
        else $error("pixel count out of range");

    // a group short of sixteen only closes a frame
    a_short: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser && m_tdata[GROUP_W +: COUNT_W] != GROUP_PIXELS |-> m_tlast)
        else $error("short group without frame end");

endmodule

bind huffman_rle_delta_image_decoder_top hrld_checker u_hrld_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
